[hw/rtl/assert_macros.svh]
// assertion helpers used by the top level
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies a consequence in the same cycle
`define OASM_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// condition implies a consequence in the following cycle
`define OASM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[hw/rtl/oasm_pkg.sv]
// shared constants, types and register codes of the oversample average block
// no dependencies
package oasm_pkg;

    localparam int FRAMES      = 5;
    localparam int SAMPLE_BITS = 12;
    localparam int CHANNELS    = 6;
    localparam int STEER_CH    = 2;

    // calibration registers
    localparam int CFG_W   = 12;
    localparam int CFG_N   = 5;
    localparam int CIDX_W  = $clog2(CFG_N);

    localparam logic [CIDX_W-1:0] REG_ADC_MIN = CIDX_W'(0);
    localparam logic [CIDX_W-1:0] REG_ADC_MAX = CIDX_W'(1);
    localparam logic [CIDX_W-1:0] REG_MM_MIN  = CIDX_W'(2);
    localparam logic [CIDX_W-1:0] REG_MM_MAX  = CIDX_W'(3);
    localparam logic [CIDX_W-1:0] REG_CENTER  = CIDX_W'(4);

    localparam logic [CFG_W-1:0]        ADC_MIN_RST = CFG_W'(0);
    localparam logic [CFG_W-1:0]        ADC_MAX_RST = CFG_W'(4095);
    localparam logic signed [CFG_W-1:0] MM_MIN_RST  = -CFG_W'(100);
    localparam logic signed [CFG_W-1:0] MM_MAX_RST  = CFG_W'(100);
    localparam logic [CFG_W-1:0]        CENTER_RST  = CFG_W'(2048);

    // frame counter
    localparam int CNT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    // accumulator and reciprocal divide by FRAMES
    localparam int SH_L    = $clog2(FRAMES);
    localparam int SUM_W   = SAMPLE_BITS + SH_L;
    localparam int DIV_SH  = SUM_W + SH_L;
    localparam int RECIP_W = SUM_W + 2;
    localparam int RECIP   = ((1 << DIV_SH) + FRAMES - 1) / FRAMES;
    localparam int MPROD_W = SUM_W + RECIP_W;

    // steering arithmetic
    localparam int RD_W    = (SAMPLE_BITS > CFG_W) ? SAMPLE_BITS : CFG_W;
    localparam int DELTA_W = RD_W + 1;
    localparam int SPAN_W  = CFG_W + 1;
    localparam int PROD_W  = DELTA_W + SPAN_W;
    localparam int NUM_W   = PROD_W + 1;
    localparam int STEP_W  = $clog2(NUM_W);
    localparam int OUT_W   = 16;

    typedef struct packed {
        logic take;   // frame accepted this cycle
        logic last;   // accepted frame closes the set
        logic mul;    // closed sum is ready for the reciprocal multiply
    } t_lane_ctl;

    typedef struct packed {
        logic [CFG_W-1:0]        adc_min;
        logic [CFG_W-1:0]        adc_max;
        logic signed [CFG_W-1:0] mm_min;
        logic signed [CFG_W-1:0] mm_max;
        logic [CFG_W-1:0]        center;
    } t_cal;

endpackage

[hw/rtl/oversample_average_steering_map_top.sv]
// path: closing frame -> r_p1 -> r_p2 -> steering states -> r_done -> o_out_valid
// throughput: one frame per cycle while o_in_stall is low; a set stays held until its
//   request is taken, so the next closing frame waits on the serial steering divider
// reset: synchronous active low; clears sums, frame counter and handshake state and
//   loads the calibration defaults (adc 0..4095, travel -100..100, center 2048)
`include "assert_macros.svh"

// top level: six accumulate lanes, the steering merge stage and the calibration registers
// depends on oasm_pkg, oasm_lane and oasm_steer
module oversample_average_steering_map_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // calibration write port
    input  logic                              i_cfg_we,
    input  logic [oasm_pkg::CIDX_W-1:0]       i_cfg_idx,
    input  logic [oasm_pkg::CFG_W-1:0]        i_cfg_data,

    // conversion frame request
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [oasm_pkg::SAMPLE_BITS-1:0]  i_pedal_a,
    input  logic [oasm_pkg::SAMPLE_BITS-1:0]  i_brake_pressure_a,
    input  logic [oasm_pkg::SAMPLE_BITS-1:0]  i_steering_raw,
    input  logic [oasm_pkg::SAMPLE_BITS-1:0]  i_pedal_b,
    input  logic [oasm_pkg::SAMPLE_BITS-1:0]  i_brake_pressure_b,
    input  logic [oasm_pkg::SAMPLE_BITS-1:0]  i_brake_hall,

    // averaged result request
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [oasm_pkg::SAMPLE_BITS-1:0]  o_mean_pedal_a,
    output logic [oasm_pkg::SAMPLE_BITS-1:0]  o_mean_brake_pressure_a,
    output logic [oasm_pkg::SAMPLE_BITS-1:0]  o_mean_steering,
    output logic [oasm_pkg::SAMPLE_BITS-1:0]  o_mean_pedal_b,
    output logic [oasm_pkg::SAMPLE_BITS-1:0]  o_mean_brake_pressure_b,
    output logic [oasm_pkg::SAMPLE_BITS-1:0]  o_mean_brake_hall,
    output logic signed [oasm_pkg::OUT_W-1:0] o_steering_mm
);
    import oasm_pkg::*;

    // calibration registers
    t_cal r_cal;

    // frame sequencing
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;     // a closed set is in the lanes or waiting at the output
    logic             r_p1;       // closed sums captured in the lanes
    logic             r_p2;       // lane means valid, steering can start
    logic             r_out_vld;

    logic             last;
    logic             in_acc;
    logic             out_acc;
    logic             steer_done;
    t_lane_ctl        lane_ctl;

    logic [SAMPLE_BITS-1:0] samples [CHANNELS];
    logic [SAMPLE_BITS-1:0] means   [CHANNELS];

    // the set-closing frame waits until the previous set's request is taken;
    // all other frames keep flowing into the accumulators
    assign last       = (r_cnt == CNT_W'(FRAMES - 1));
    assign o_in_stall = r_busy && last;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_vld && !i_out_stall;

    assign lane_ctl.take = in_acc;
    assign lane_ctl.last = last;
    assign lane_ctl.mul  = r_p1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal.adc_min <= ADC_MIN_RST;
            r_cal.adc_max <= ADC_MAX_RST;
            r_cal.mm_min  <= MM_MIN_RST;
            r_cal.mm_max  <= MM_MAX_RST;
            r_cal.center  <= CENTER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ADC_MIN: r_cal.adc_min <= i_cfg_data;
                REG_ADC_MAX: r_cal.adc_max <= i_cfg_data;
                REG_MM_MIN:  r_cal.mm_min  <= $signed(i_cfg_data);
                REG_MM_MAX:  r_cal.mm_max  <= $signed(i_cfg_data);
                REG_CENTER:  r_cal.center  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_busy    <= 1'b0;
            r_p1      <= 1'b0;
            r_p2      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cnt <= last ? '0 : r_cnt + 1'b1;
            end
            r_p1 <= in_acc && last;
            r_p2 <= r_p1;
            if (in_acc && last) begin
                r_busy <= 1'b1;
            end else if (out_acc) begin
                r_busy <= 1'b0;
            end
            if (steer_done) begin
                r_out_vld <= 1'b1;
            end else if (out_acc) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // channel order follows the frame layout: first converter 0..2, second 0..2
    assign samples[0] = i_pedal_a;
    assign samples[1] = i_brake_pressure_a;
    assign samples[2] = i_steering_raw;
    assign samples[3] = i_pedal_b;
    assign samples[4] = i_brake_pressure_b;
    assign samples[5] = i_brake_hall;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        oasm_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (lane_ctl),
            .i_sample (samples[g]),
            .o_mean   (means[g])
        );
    end

    // lane means stay put while the set is busy, so they feed the outputs directly
    oasm_steer u_steer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_p2),
        .i_mean  (means[STEER_CH]),
        .i_cal   (r_cal),
        .o_done  (steer_done),
        .o_mm    (o_steering_mm)
    );

    assign o_out_valid             = r_out_vld;
    assign o_mean_pedal_a          = means[0];
    assign o_mean_brake_pressure_a = means[1];
    assign o_mean_steering         = means[2];
    assign o_mean_pedal_b          = means[3];
    assign o_mean_brake_pressure_b = means[4];
    assign o_mean_brake_hall       = means[5];

    `OASM_ASSERT_NOW(a_vld_busy, r_out_vld, r_busy, "result valid without a set in flight")
    `OASM_ASSERT_NOW(a_no_overrun, r_busy, !(in_acc && last), "set closed while one in flight")
    `OASM_ASSERT_NOW(a_done_once, steer_done, !r_out_vld, "steering finished over a held result")
    `OASM_ASSERT_NEXT(a_cnt_wrap, in_acc && last, r_cnt == '0, "frame counter did not wrap")

endmodule

[hw/rtl/oasm_lane.sv]
// one channel lane: running sum over a set of frames and mean by reciprocal multiply
// depends on oasm_pkg
module oasm_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  oasm_pkg::t_lane_ctl             i_ctl,
    input  logic [oasm_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic [oasm_pkg::SAMPLE_BITS-1:0] o_mean
);
    import oasm_pkg::*;

    logic [SUM_W-1:0]   r_acc;
    logic [SUM_W-1:0]   r_final;
    logic [SUM_W-1:0]   n_sum;
    logic [RECIP_W-1:0] recip_c;
    logic [MPROD_W-1:0] r_prod;

    assign n_sum   = r_acc + SUM_W'(i_sample);
    assign recip_c = RECIP_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.take) begin
            r_acc <= i_ctl.last ? '0 : n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.take && i_ctl.last) begin
            r_final <= n_sum;
        end
        if (i_ctl.mul) begin
            r_prod <= MPROD_W'(r_final) * MPROD_W'(recip_c);
        end
    end

    assign o_mean = r_prod[DIV_SH +: SAMPLE_BITS];

endmodule

[hw/rtl/oasm_steer.sv]
// merge stage: clamps the steering mean, scales it to travel and divides by the span
// depends on oasm_pkg; bit-serial restoring divider, one quotient bit per cycle
module oasm_steer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [oasm_pkg::SAMPLE_BITS-1:0] i_mean,
    input  oasm_pkg::t_cal                   i_cal,
    output logic                             o_done,
    output logic signed [oasm_pkg::OUT_W-1:0] o_mm
);
    import oasm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_ABS  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [NUM_W-1:0] SAT_POS = NUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic [NUM_W-1:0] SAT_NEG = NUM_W'(1 << (OUT_W - 1));

    logic [2:0]                r_state;
    logic [STEP_W-1:0]         r_step;
    logic                      r_done;
    logic signed [DELTA_W-1:0] r_delta;
    logic signed [SPAN_W-1:0]  r_span_adc;
    logic signed [SPAN_W-1:0]  r_span_mm;
    logic signed [NUM_W-1:0]   r_num;
    logic [NUM_W-1:0]          r_work;
    logic [CFG_W-1:0]          r_rem;
    logic [CFG_W-1:0]          r_dvs;
    logic                      r_neg;
    logic                      r_zero;
    logic signed [OUT_W-1:0]   r_mm;

    logic [RD_W-1:0]           rd;
    logic [RD_W-1:0]           rd_min;
    logic [RD_W-1:0]           rd_max;
    logic [RD_W-1:0]           clamped;
    logic signed [SPAN_W-1:0]  half_mag;
    logic signed [SPAN_W-1:0]  half;
    logic signed [PROD_W-1:0]  prod;
    logic [CFG_W:0]            trial;
    logic                      ge;

    // floor test wins when the floor sits above the ceiling
    assign rd      = RD_W'(i_mean);
    assign rd_min  = RD_W'(i_cal.adc_min);
    assign rd_max  = RD_W'(i_cal.adc_max);
    assign clamped = (rd < rd_min) ? rd_min : ((rd > rd_max) ? rd_max : rd);

    // half span, truncated toward zero, carrying the sign of the offset
    assign half_mag = (r_span_adc + $signed(SPAN_W'(r_span_adc[SPAN_W-1]))) >>> 1;
    assign half     = r_delta[DELTA_W-1] ? -half_mag : half_mag;
    assign prod     = r_delta * r_span_mm;

    assign trial = {r_rem, r_work[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_state <= ST_ABS;
                end
                ST_ABS: begin
                    r_step  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(NUM_W - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_delta    <= $signed({1'b0, clamped}) - $signed({1'b0, RD_W'(i_cal.center)});
                    r_span_adc <= $signed({1'b0, i_cal.adc_max}) - $signed({1'b0, i_cal.adc_min});
                    r_span_mm  <= $signed({i_cal.mm_max[CFG_W-1], i_cal.mm_max})
                                - $signed({i_cal.mm_min[CFG_W-1], i_cal.mm_min});
                end
            end
            ST_MUL: begin
                r_num <= NUM_W'(prod) + NUM_W'(half);
            end
            ST_ABS: begin
                r_work <= r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
                r_neg  <= r_num[NUM_W-1] ^ r_span_adc[SPAN_W-1];
                r_dvs  <= r_span_adc[SPAN_W-1] ? CFG_W'(-r_span_adc) : CFG_W'(r_span_adc);
                r_zero <= (r_span_adc == '0);
                r_rem  <= '0;
            end
            ST_DIV: begin
                r_rem  <= ge ? CFG_W'(trial - {1'b0, r_dvs}) : trial[CFG_W-1:0];
                r_work <= {r_work[NUM_W-2:0], ge};
            end
            ST_FIN: begin
                if (r_zero) begin
                    r_mm <= '0;
                end else if (r_neg) begin
                    r_mm <= (r_work > SAT_NEG) ? OUT_W'(SAT_NEG) : -OUT_W'(r_work);
                end else begin
                    r_mm <= (r_work > SAT_POS) ? OUT_W'(SAT_POS) : OUT_W'(r_work);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_mm   = r_mm;

endmodule
